### rtl/sfws_pkg.sv
// Shared types and constants for the sharpest frame window selector
`timescale 1ns / 1ps
package sfws_pkg;
	localparam int MaxKeep = 16;
	localparam int WinAw   = $clog2(MaxKeep);
	localparam int FillW   = WinAw + 1;
	localparam int DivW    = 33;
	localparam int DivCntW = $clog2(DivW);

	localparam logic [1:0] REG_KEEP  = 2'd0;
	localparam logic [1:0] REG_SKIP  = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT_CAND,
		ST_WAIT_WRITE,
		ST_SCAN,
		ST_EMIT
	} sfws_state_t;

	typedef struct packed {
		logic             clear;
		logic             append;
		logic             scan;
		logic [FillW-1:0] cap;
	} win_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] best_index;
		logic [15:0] peak_score;
	} win_res_t;

	typedef struct packed {
		logic        done;
		logic [15:0] rem;
	} mod_res_t;
endpackage

### rtl/sfws_mod.sv
// Bit-serial restoring modulo unit, one dividend bit per cycle
`timescale 1ns / 1ps
module sfws_mod import sfws_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] dividend,
	input  logic [15:0]     divisor,
	output mod_res_t        res
);
	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivW-1:0]    dvd_q;
	logic [15:0]        rem_q;
	logic [16:0]        shifted;
	logic [16:0]        rem_next;

	always_comb begin
		shifted  = {rem_q, dvd_q[DivW-1]};
		rem_next = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DivCntW'(DivW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next[15:0];
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;
endmodule

### rtl/sfws_window.sv
// Circular candidate window with a sequential argmax scan
`timescale 1ns / 1ps
module sfws_window import sfws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  win_cmd_t    cmd,
	input  logic [31:0] append_index,
	input  logic [15:0] append_score,
	output win_res_t    res
);
	logic [15:0]      score_mem [MaxKeep];
	logic [31:0]      index_mem [MaxKeep];
	logic [WinAw-1:0] head_q;
	logic [FillW-1:0] fill_q;
	logic             active_q;
	logic             dv_q;
	logic             done_q;
	logic [FillW-1:0] iss_q;
	logic [FillW-1:0] pos_q;
	logic [15:0]      rd_score_q;
	logic [31:0]      rd_index_q;
	logic [15:0]      peak_score_q;
	logic [31:0]      best_index_q;
	logic             over;
	logic [FillW-1:0] drop;
	logic [WinAw-1:0] head_app;
	logic [FillW-1:0] fill_app;
	logic [WinAw-1:0] wr_addr;
	logic [WinAw-1:0] rd_addr;

	always_comb begin
		over     = fill_q >= cmd.cap;
		drop     = fill_q - cmd.cap + 1'b1;
		head_app = over ? head_q + drop[WinAw-1:0] : head_q;
		fill_app = over ? cmd.cap - 1'b1 : fill_q;
		wr_addr  = head_app + fill_app[WinAw-1:0];
		rd_addr  = head_q + iss_q[WinAw-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			score_mem[wr_addr] <= append_score;
			index_mem[wr_addr] <= append_index;
		end
		rd_score_q <= score_mem[rd_addr];
		rd_index_q <= index_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			fill_q   <= '0;
			active_q <= 1'b0;
			dv_q     <= 1'b0;
			done_q   <= 1'b0;
			iss_q    <= '0;
			pos_q    <= '0;
		end else begin
			done_q <= !cmd.scan && active_q && dv_q && (pos_q == fill_q - 1'b1);
			if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.append) begin
				head_q <= head_app;
				fill_q <= fill_app + 1'b1;
			end
			if (cmd.scan) begin
				active_q <= 1'b1;
				iss_q    <= '0;
				pos_q    <= '0;
				dv_q     <= 1'b0;
			end else if (active_q) begin
				if (iss_q < fill_q) begin
					iss_q <= iss_q + 1'b1;
					dv_q  <= 1'b1;
				end else begin
					dv_q <= 1'b0;
				end
				if (dv_q) begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == fill_q - 1'b1) begin
						active_q <= 1'b0;
						fill_q   <= '0;
					end
				end
			end
		end
	end

	// strict compare keeps the oldest entry on ties
	always_ff @(posedge clk) begin
		if (dv_q && (pos_q == '0 || rd_score_q > peak_score_q)) begin
			peak_score_q <= rd_score_q;
			best_index_q <= rd_index_q;
		end
	end

	assign res.done       = done_q;
	assign res.best_index = best_index_q;
	assign res.peak_score = peak_score_q;
endmodule

### rtl/sharpest_frame_window_selector.sv
// Top level: sequencer for candidate test, window update, write test and emit
//
// channel  | direction | handshake                 | payload
// frame    | in        | frame_valid / frame_stall | frame_index, sharpness_score, end_of_stream
// choice   | out       | choice_valid/choice_stall | chosen_index, chosen_score
// cfg      | in        | cfg_we                    | cfg_index, cfg_wdata
//
// End of stream and limited frames are taken in idle without a modulo pass. A non-candidate
// needs one modulo pass; a candidate needs two, and with a result adds a window scan and emit.
// The shared bit-serial modulo unit sets the pace. frame_stall is high while busy.
// A waiting result on the choice side holds the next result in the emit state.
// Reset clears config to keep 0, period 1, limit 0 and empties the window.
`timescale 1ns / 1ps
module sharpest_frame_window_selector import sfws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [31:0] frame_index,
	input  logic [15:0] sharpness_score,
	input  logic        end_of_stream,
	output logic        choice_valid,
	input  logic        choice_stall,
	output logic [31:0] chosen_index,
	output logic [15:0] chosen_score,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	sfws_state_t      state_q, state_d;
	logic [4:0]       keep_q;
	logic [15:0]      skip_q;
	logic [15:0]      limit_q;
	logic [31:0]      phase_q;
	logic [15:0]      emitted_q;
	logic [31:0]      idx_q;
	logic [15:0]      score_q;
	logic             choice_valid_q;
	logic [31:0]      chosen_index_q;
	logic [15:0]      chosen_score_q;
	logic [4:0]       keff;
	logic [15:0]      seff;
	logic             limited;
	logic             accept;
	logic             mod_start;
	logic [DivW-1:0]  mod_dividend;
	mod_res_t         mod_res;
	win_cmd_t         win_cmd;
	win_res_t         win_res;
	logic             latch_in;
	logic             phase_clr;
	logic             phase_inc;
	logic             emitted_clr;
	logic             load_out;
	logic             cand;

	always_comb begin
		keff    = (keep_q > 5'(MaxKeep)) ? 5'(MaxKeep) : keep_q;
		seff    = (skip_q == '0) ? 16'd1 : skip_q;
		limited = (limit_q != '0) && (emitted_q >= limit_q);
		accept  = frame_valid && !frame_stall;
		cand    = (keff == '0) ? (mod_res.rem == '0) : (mod_res.rem < {11'd0, keff});
	end

	assign frame_stall = (state_q != ST_IDLE);

	sfws_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (seff),
		.res      (mod_res)
	);

	sfws_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (win_cmd),
		.append_index (idx_q),
		.append_score (score_q),
		.res          (win_res)
	);

	always_comb begin
		state_d      = state_q;
		mod_start    = 1'b0;
		mod_dividend = '0;
		win_cmd      = '0;
		win_cmd.cap  = (keff == '0) ? FillW'(1) : FillW'(keff);
		latch_in     = 1'b0;
		phase_clr    = 1'b0;
		phase_inc    = 1'b0;
		emitted_clr  = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (end_of_stream) begin
						win_cmd.clear = 1'b1;
						phase_clr     = 1'b1;
						emitted_clr   = 1'b1;
					end else if (!limited) begin
						latch_in     = 1'b1;
						mod_start    = 1'b1;
						mod_dividend = {1'b0, frame_index} + {28'd0, keff};
						state_d      = ST_WAIT_CAND;
					end
				end
			end
			ST_WAIT_CAND: begin
				if (mod_res.done) begin
					phase_inc = 1'b1;
					if (cand) begin
						win_cmd.append = 1'b1;
						mod_start      = 1'b1;
						mod_dividend   = {1'b0, (keff != '0) ? phase_q + 1'b1 : phase_q};
						state_d        = ST_WAIT_WRITE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WAIT_WRITE: begin
				if (mod_res.done) begin
					if (mod_res.rem == '0) begin
						win_cmd.scan = 1'b1;
						state_d      = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				if (win_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!choice_valid_q || !choice_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			keep_q         <= '0;
			skip_q         <= 16'd1;
			limit_q        <= '0;
			phase_q        <= '0;
			emitted_q      <= '0;
			choice_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEEP:  keep_q  <= cfg_wdata[4:0];
					REG_SKIP:  skip_q  <= cfg_wdata;
					REG_LIMIT: limit_q <= cfg_wdata;
					default:   ;
				endcase
			end
			if (phase_clr) begin
				phase_q <= '0;
			end else if (phase_inc) begin
				phase_q <= phase_q + 1'b1;
			end
			if (emitted_clr) begin
				emitted_q <= '0;
			end else if (load_out && emitted_q != 16'hFFFF) begin
				emitted_q <= emitted_q + 1'b1;
			end
			if (load_out) begin
				choice_valid_q <= 1'b1;
			end else if (!choice_stall) begin
				choice_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_in) begin
			idx_q   <= frame_index;
			score_q <= sharpness_score;
		end
		if (load_out) begin
			chosen_index_q <= win_res.best_index;
			chosen_score_q <= win_res.peak_score;
		end
	end

	assign choice_valid = choice_valid_q;
	assign chosen_index = chosen_index_q;
	assign chosen_score = chosen_score_q;

	a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_res.done |-> (state_q == ST_WAIT_CAND || state_q == ST_WAIT_WRITE))
		else $error("modulo result outside a wait state");

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		win_res.done |-> (state_q == ST_SCAN))
		else $error("window scan finished outside scan state");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(choice_valid) |-> $past(state_q) == ST_EMIT)
		else $error("result raised without emit");

	a_one_load_per_emit: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> state_q == ST_IDLE)
		else $error("emit did not return to idle");
endmodule

### tb/tb_sharpest_frame_window_selector.sv
// Self-checking testbench for the sharpest frame window selector, with its own window model
`timescale 1ns / 1ps
module tb_sharpest_frame_window_selector;
	import sfws_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int TARGET_ITEMS = 1750;

	typedef struct packed {
		logic [31:0] idx;
		logic [15:0] score;
		logic        eos;
	} frame_t;

	typedef struct packed {
		logic [31:0] idx;
		logic [15:0] score;
	} choice_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        frame_valid = 1'b0;
	logic        frame_stall;
	logic [31:0] frame_index = '0;
	logic [15:0] sharpness_score = '0;
	logic        end_of_stream = 1'b0;
	logic        choice_valid;
	logic        choice_stall = 1'b0;
	logic [31:0] chosen_index;
	logic [15:0] chosen_score;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_KEEP;
	logic [15:0] cfg_wdata = '0;

	sharpest_frame_window_selector dut (.*);

	// model state
	logic [4:0]  keep_r = '0;
	logic [15:0] skip_r = 16'd1;
	logic [15:0] limit_r = '0;
	logic [15:0] win_score [MaxKeep];
	logic [31:0] win_index [MaxKeep];
	int          win_fill = 0;
	logic [31:0] phase_ctr = '0;
	logic [15:0] emit_ctr = '0;

	frame_t  pending_frames [$];
	choice_t due_choices [$];
	frame_t  next_frame;
	choice_t head;
	logic    took = 1'b0;
	int      queued_items = 0;
	int      errors = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// works out the chosen frame, if any, for one accepted transaction
	task automatic select_frame(input logic [31:0] idx, input logic [15:0] score,
			input logic eos);
		int          k;
		int          cap;
		int          best;
		int          j;
		logic [31:0] s;
		logic [63:0] wide;
		logic        is_cand;
		logic        do_write;
		choice_t     pick;
		if (eos) begin
			win_fill = 0;
			phase_ctr = '0;
			emit_ctr = '0;
			return;
		end
		if (limit_r != 0 && emit_ctr >= limit_r)
			return;
		k = (keep_r > MaxKeep) ? MaxKeep : int'(keep_r);
		s = (skip_r == 0) ? 32'd1 : {16'd0, skip_r};
		if (k == 0) begin
			is_cand = (idx % s) == 0;
		end else begin
			wide = {32'd0, idx} + 64'(k);
			is_cand = (wide % {32'd0, s}) < 64'(k);
		end
		if (!is_cand) begin
			phase_ctr++;
			return;
		end
		cap = (k == 0) ? 1 : k;
		while (win_fill >= cap) begin
			for (j = 1; j < win_fill; j++) begin
				win_score[j-1] = win_score[j];
				win_index[j-1] = win_index[j];
			end
			win_fill--;
		end
		win_score[win_fill] = score;
		win_index[win_fill] = idx;
		win_fill++;
		if (k != 0)
			phase_ctr++;
		do_write = (phase_ctr % s) == 0;
		if (k == 0)
			phase_ctr++;
		if (!do_write)
			return;
		best = 0;
		if (k != 0) begin
			for (j = 1; j < win_fill; j++)
				if (win_score[j] > win_score[best])
					best = j;
		end
		pick.idx = win_index[best];
		pick.score = win_score[best];
		due_choices = {due_choices, pick};
		win_fill = 0;
		if (emit_ctr != 16'hFFFF)
			emit_ctr++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else if (arst_n) begin
			if (choice_valid && !choice_stall) begin
				if (due_choices.size() == 0) begin
					flag_mismatch("unexpected transaction", chosen_index, '0);
				end else begin
					head = due_choices[0];
					due_choices.delete(0);
					if (chosen_index !== head.idx)
						flag_mismatch("chosen_index", chosen_index, head.idx);
					if (chosen_score !== head.score)
						flag_mismatch("chosen_score", {16'd0, chosen_score}, {16'd0, head.score});
				end
			end
			took = frame_valid && !frame_stall;
			if (took)
				select_frame(frame_index, sharpness_score, end_of_stream);
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!frame_valid || took)) begin
			if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_frame = pending_frames[0];
				pending_frames.delete(0);
				frame_valid <= 1'b1;
				frame_index <= next_frame.idx;
				sharpness_score <= next_frame.score;
				end_of_stream <= next_frame.eos;
			end else begin
				frame_valid <= 1'b0;
			end
		end
		choice_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	task automatic push_frame(input logic [31:0] idx, input logic [15:0] score, input logic eos);
		frame_t fr;
		fr.idx = idx;
		fr.score = score;
		fr.eos = eos;
		pending_frames = {pending_frames, fr};
		queued_items++;
	endtask

	task automatic push_eos();
		push_frame($urandom, 16'($urandom), 1'b1);
	endtask

	// block idle: nothing queued, nothing due, then let an unproductive transaction finish
	task automatic settle();
		while (pending_frames.size() > 0 || frame_valid || due_choices.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] which, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (which)
			REG_KEEP:  keep_r = value[4:0];
			REG_SKIP:  skip_r = value;
			REG_LIMIT: limit_r = value;
			default: ;
		endcase
	endtask

	task automatic queue_stream(input int len, input logic [31:0] first, input bit lead_eos);
		int i;
		if (lead_eos)
			push_eos();
		for (i = 0; i < len; i++)
			push_frame(first + i, ($urandom_range(3) == 0) ? 16'($urandom_range(3))
				: 16'($urandom), 1'b0);
	endtask

	initial begin
		int          i;
		int          n;
		logic [15:0] kv;
		logic [15:0] sv;
		logic [15:0] lv;
		logic [31:0] start;
		logic [15:0] ties [8];
		ties = '{16'd7, 16'd7, 16'd3, 16'd7, 16'd2, 16'd9, 16'd9, 16'd1};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: every frame is chosen
		push_frame(32'd0, 16'd0, 1'b0);
		push_frame(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		push_eos();
		settle();
		// oversized keep, zero period, limit of two; end of stream after the limit
		write_reg(REG_KEEP, 16'hFFFF);
		write_reg(REG_SKIP, 16'd0);
		write_reg(REG_LIMIT, 16'd2);
		push_frame(32'hFFFF_FFF0, 16'd5, 1'b0);
		push_frame(32'hFFFF_FFF1, 16'd9, 1'b0);
		push_frame(32'hFFFF_FFF2, 16'd4, 1'b0);
		push_eos();
		push_frame(32'hFFFF_FFF3, 16'd1, 1'b0);
		settle();
		// candidate test across index wrap, tied scores
		write_reg(REG_KEEP, 16'd3);
		write_reg(REG_SKIP, 16'd4);
		write_reg(REG_LIMIT, 16'd0);
		push_eos();
		for (i = 0; i < 8; i++)
			push_frame(32'hFFFF_FFFC + i, ties[i], 1'b0);
		settle();
		// fill a wide window, then narrow it without ending the stream
		write_reg(REG_KEEP, 16'd16);
		write_reg(REG_SKIP, 16'd20);
		write_reg(REG_LIMIT, 16'hFFFF);
		for (i = 4; i < 9; i++)
			push_frame(i, 16'($urandom), 1'b0);
		settle();
		write_reg(REG_KEEP, 16'd1);
		push_frame(32'd9, 16'($urandom), 1'b0);
		push_frame(32'd10, 16'($urandom), 1'b0);

		while (queued_items < TARGET_ITEMS) begin
			settle();
			if (queued_items < TARGET_ITEMS / 3) begin
				send_idle_pct = 33;
				recv_stall_pct = 79;
			end else if (queued_items < 2 * TARGET_ITEMS / 3) begin
				send_idle_pct = 79;
				recv_stall_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case ($urandom_range(9))
				0: kv = 16'd0;
				1: kv = 16'd16;
				2: kv = 16'($urandom_range(17, 31)) | (16'($urandom) & 16'hFFE0);
				default: kv = 16'($urandom_range(0, 16));
			endcase
			case ($urandom_range(19))
				0: sv = 16'd0;
				1: sv = 16'hFFFF;
				2: sv = 16'($urandom);
				3: sv = 16'd1;
				default: sv = 16'($urandom_range(2, 12));
			endcase
			case ($urandom_range(9))
				0: lv = 16'($urandom_range(1, 4));
				1: lv = 16'hFFFF;
				2: lv = 16'($urandom_range(5, 65535));
				default: lv = 16'd0;
			endcase
			write_reg(REG_KEEP, kv);
			write_reg(REG_SKIP, sv);
			write_reg(REG_LIMIT, lv);
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(9) < 8) begin
					case ($urandom_range(3))
						0: start = 32'd0;
						1: start = ((sv == 0) ? 32'd1 : {16'd0, sv}) * $urandom_range(1000);
						2: start = 32'hFFFF_FFFF - $urandom_range(40);
						default: start = $urandom;
					endcase
					queue_stream($urandom_range(8, 48), start, $urandom_range(3) != 0);
				end else begin
					// noise: scattered indices and stray stream ends
					repeat ($urandom_range(4, 16)) begin
						if ($urandom_range(7) == 0)
							push_eos();
						else
							push_frame($urandom, 16'($urandom), 1'b0);
					end
				end
			end
		end
		settle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
